/* rtl/core/text_line_charset_transcoder_unit_macros.svh */
// Assertion macros shared by the checker of the charset transcoder.
`ifndef TEXT_LINE_CHARSET_TRANSCODER_UNIT_MACROS_SVH
`define TEXT_LINE_CHARSET_TRANSCODER_UNIT_MACROS_SVH

// A implies B in the same cycle, checked outside reset.
`define TTC_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("transcoder check failed");

// A implies B in the next cycle, checked outside reset.
`define TTC_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("transcoder check failed");

// A implies B in the next cycle, checked in reset as well.
`define TTC_ASSERT_NEXT_ALL(label, clk, a, b) \
    label: assert property (@(posedge clk) (a) |=> (b)) \
        else $error("transcoder check failed");

`endif

/* rtl/core/ttc_pkg.sv */
package ttc_pkg;

    // Conversion modes held in the mode register.
    localparam logic [2:0] MODE_LATIN1      = 3'd0;
    localparam logic [2:0] MODE_UTF8_RAW    = 3'd1;
    localparam logic [2:0] MODE_UTF8_LATIN1 = 3'd2;
    localparam logic [2:0] MODE_UTF8_CP1252 = 3'd3;
    localparam logic [2:0] MODE_L1_CP1252   = 3'd4;

    // Character codes with a special meaning.
    localparam logic [7:0] CHAR_UNMAPPED = 8'h0B;
    localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
    localparam logic [7:0] CHAR_CR       = 8'h0D;

    // Open UTF-8 sequence.
    typedef struct packed {
        logic [1:0]  pending;
        logic [20:0] codepoint;
    } t_seq_state;

    // One result item.
    typedef struct packed {
        logic [7:0] out_char;
        logic [5:0] char_position;
        logic       line_done;
        logic       status;
    } t_result;

    // Latin-1 byte to its Windows-1252 display code.
    function automatic logic [7:0] latin1_to_cp1252(input logic [7:0] c);
        logic [7:0] r;
        if ((c >= 8'h20 && c <= 8'h7E) || c >= 8'hA0) begin
            r = c;
        end else if (c < 8'h80 || c == 8'h81 || c == 8'h8D || c == 8'h8F ||
                     c == 8'h90 || c == 8'h9D) begin
            r = CHAR_UNMAPPED;
        end else begin
            r = c;
        end
        return r;
    endfunction

    // Unicode code point to Windows-1252.
    function automatic logic [7:0] codepoint_to_cp1252(input logic [20:0] cp);
        logic [7:0] r;
        if (cp < 21'h80 || (cp >= 21'hA0 && cp <= 21'hFF)) begin
            r = cp[7:0];
        end else begin
            unique case (cp)
                21'h20AC: r = 8'h80;
                21'h201A: r = 8'h82;
                21'h0192: r = 8'h83;
                21'h201E: r = 8'h84;
                21'h2026: r = 8'h85;
                21'h2020: r = 8'h86;
                21'h2021: r = 8'h87;
                21'h02C6: r = 8'h88;
                21'h2030: r = 8'h89;
                21'h0160: r = 8'h8A;
                21'h2039: r = 8'h8B;
                21'h0152: r = 8'h8C;
                21'h017D: r = 8'h8E;
                21'h2018: r = 8'h91;
                21'h2019: r = 8'h92;
                21'h201C: r = 8'h93;
                21'h201D: r = 8'h94;
                21'h2022: r = 8'h95;
                21'h2013: r = 8'h96;
                21'h2014: r = 8'h97;
                21'h02DC: r = 8'h98;
                21'h2122: r = 8'h99;
                21'h0161: r = 8'h9A;
                21'h203A: r = 8'h9B;
                21'h0153: r = 8'h9C;
                21'h017E: r = 8'h9E;
                21'h0178: r = 8'h9F;
                default:  r = CHAR_UNMAPPED;
            endcase
        end
        return r;
    endfunction

endpackage

/* rtl/core/ttc_decoder.sv */
module ttc_decoder
    import ttc_pkg::*;
#(
    parameter int LINE_CAPACITY = 64,
    localparam int CW = $clog2(LINE_CAPACITY)
) (
    input  logic [2:0]    i_mode,
    input  logic [CW-1:0] i_line_count,
    input  t_seq_state    i_seq,
    input  logic [7:0]    i_data_byte,
    input  logic          i_end_of_file,
    input  logic          i_read_failed,
    output logic [CW-1:0] o_line_count,
    output t_seq_state    o_seq,
    output logic          o_res_valid,
    output t_result       o_res
);

    logic [2:0]  mode;
    logic [1:0]  pend_dec;
    logic [20:0] cp_shift;
    logic [2:0]  lead_len;
    logic [20:0] lead_cp;
    logic        lead_ok;
    logic        line_full;
    logic        no_room;

    // Mode codes beyond the defined ones behave as plain Latin-1.
    assign mode = (i_mode > MODE_L1_CP1252) ? MODE_LATIN1 : i_mode;

    assign pend_dec = i_seq.pending - 2'd1;
    assign cp_shift = {i_seq.codepoint[14:0], i_data_byte[5:0]};
    assign line_full = {1'b0, i_line_count} >= (CW+1)'(LINE_CAPACITY - 1);

    // Classify a lead byte by its length and the payload bits it carries.
    always_comb begin
        lead_ok  = 1'b1;
        lead_len = 3'd0;
        lead_cp  = '0;
        priority if (i_data_byte[7:5] == 3'b110) begin
            lead_len = 3'd2;
            lead_cp  = {16'd0, i_data_byte[4:0]};
        end else if (i_data_byte[7:4] == 4'b1110) begin
            lead_len = 3'd3;
            lead_cp  = {17'd0, i_data_byte[3:0]};
        end else if (i_data_byte[7:3] == 5'b11110) begin
            lead_len = 3'd4;
            lead_cp  = {18'd0, i_data_byte[2:0]};
        end else begin
            lead_ok = 1'b0;
        end
    end

    assign no_room = ((CW+3)'(i_line_count) + (CW+3)'(lead_len)) >= (CW+3)'(LINE_CAPACITY);

    // Next decode state and the result caused by this byte.
    always_comb begin
        o_line_count = i_line_count;
        o_seq        = i_seq;
        o_res_valid  = 1'b0;
        o_res        = '0;
        o_res.char_position = 6'(i_line_count);
        priority if (i_read_failed) begin
            o_res_valid  = 1'b1;
            o_res.line_done = 1'b1;
            o_res.status = 1'b1;
            o_line_count = '0;
            o_seq        = '0;
        end else if (i_seq.pending != 2'd0) begin
            // Inside a multi-byte sequence.
            priority if (i_end_of_file) begin
                o_res_valid  = 1'b1;
                o_res.line_done = 1'b1;
                o_line_count = '0;
                o_seq        = '0;
            end else if (i_data_byte[7:6] != 2'b10) begin
                if (mode == MODE_UTF8_RAW) begin
                    o_seq = '0;
                end else begin
                    o_res_valid  = 1'b1;
                    o_res.line_done = 1'b1;
                    o_line_count = '0;
                    o_seq        = '0;
                end
            end else if (mode == MODE_UTF8_RAW) begin
                o_seq.pending  = pend_dec;
                o_res_valid    = 1'b1;
                o_res.out_char = i_data_byte;
                o_line_count   = i_line_count + CW'(1);
            end else begin
                o_seq.pending   = pend_dec;
                o_seq.codepoint = cp_shift;
                if (pend_dec == 2'd0) begin
                    o_res_valid  = 1'b1;
                    o_line_count = i_line_count + CW'(1);
                    if (mode == MODE_UTF8_CP1252) begin
                        o_res.out_char = codepoint_to_cp1252(cp_shift);
                    end else begin
                        o_res.out_char = (cp_shift <= 21'hFF) ? cp_shift[7:0]
                                                              : CHAR_UNMAPPED;
                    end
                end
            end
        end else if (i_end_of_file || i_data_byte == CHAR_NEWLINE || line_full) begin
            o_res_valid  = 1'b1;
            o_res.line_done = 1'b1;
            o_line_count = '0;
            o_seq        = '0;
        end else if (i_data_byte == CHAR_CR) begin
            // Carriage return is dropped.
            o_res_valid = 1'b0;
        end else if (mode == MODE_LATIN1) begin
            o_res_valid    = 1'b1;
            o_res.out_char = i_data_byte;
            o_line_count   = i_line_count + CW'(1);
        end else if (mode == MODE_L1_CP1252) begin
            o_res_valid    = 1'b1;
            o_res.out_char = latin1_to_cp1252(i_data_byte);
            o_line_count   = i_line_count + CW'(1);
        end else if (i_data_byte < 8'h80) begin
            o_res_valid    = 1'b1;
            o_res.out_char = i_data_byte;
            o_line_count   = i_line_count + CW'(1);
        end else if (!lead_ok) begin
            // Invalid lead byte is dropped.
            o_res_valid = 1'b0;
        end else if (mode == MODE_UTF8_RAW && no_room) begin
            o_res_valid  = 1'b1;
            o_res.line_done = 1'b1;
            o_line_count = '0;
            o_seq        = '0;
        end else begin
            o_seq.pending   = 2'(lead_len - 3'd1);
            o_seq.codepoint = lead_cp;
        end
    end

endmodule

/* rtl/core/ttc_out_queue.sv */
module ttc_out_queue
    import ttc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_push_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_data
);

    logic    r_out_valid;
    logic    r_skd_valid;
    t_result r_out;
    t_result r_skd;
    logic    pop;

    assign pop     = r_out_valid && !i_stall;
    assign o_full  = r_skd_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // Output register with one skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (pop) begin
            if (r_skd_valid) begin
                r_out_valid <= 1'b1;
                r_skd_valid <= i_push;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (!r_out_valid) begin
            r_out_valid <= i_push;
        end else if (i_push) begin
            r_skd_valid <= 1'b1;
        end
    end

    // Payload moves without reset.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skd_valid) begin
                r_out <= r_skd;
                r_skd <= i_push_data;
            end else begin
                r_out <= i_push_data;
            end
        end else if (!r_out_valid) begin
            r_out <= i_push_data;
        end else if (i_push) begin
            r_skd <= i_push_data;
        end
    end

endmodule

/* rtl/core/text_line_charset_transcoder_unit.sv */
// The input register loads on the edge that accepts an item; the decoder is
// combinational and its result loads into the output stage. Throughput: one
// item per cycle unless a full output stage stalls the input; the decode
// state update is a single pass. A two-entry output stage lets items be
// taken while a result waits. Reset (synchronous, active low) clears the
// mode to Latin-1, the line position, any open sequence and all valid flags.
module text_line_charset_transcoder_unit
    import ttc_pkg::*;
#(
    parameter int LINE_CAPACITY = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_file,
    input  logic       i_read_failed,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_char,
    output logic [5:0] o_char_position,
    output logic       o_line_done,
    output logic       o_status
);

    localparam int CW = $clog2(LINE_CAPACITY);

    logic          r_in_valid;
    logic [7:0]    r_in_byte;
    logic          r_in_eof;
    logic          r_in_err;
    logic [2:0]    r_mode;
    logic [CW-1:0] r_line_count;
    t_seq_state    r_seq;
    logic [CW-1:0] n_line_count;
    t_seq_state    n_seq;
    logic          res_valid;
    t_result       res;
    logic          q_full;
    logic          advance;
    t_result       out_data;

    assign advance    = r_in_valid && !q_full;
    assign o_in_stall = r_in_valid && q_full;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_data_byte;
            r_in_eof  <= i_end_of_file;
            r_in_err  <= i_read_failed;
        end
    end

    // Mode register and line decode state; a mode write restarts the line.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_LATIN1;
            r_line_count <= '0;
            r_seq        <= '0;
        end else if (i_cfg_we) begin
            r_mode       <= i_cfg_data;
            r_line_count <= '0;
            r_seq        <= '0;
        end else if (advance) begin
            r_line_count <= n_line_count;
            r_seq        <= n_seq;
        end
    end

    ttc_decoder #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) u_decoder (
        .i_mode        (r_mode),
        .i_line_count  (r_line_count),
        .i_seq         (r_seq),
        .i_data_byte   (r_in_byte),
        .i_end_of_file (r_in_eof),
        .i_read_failed (r_in_err),
        .o_line_count  (n_line_count),
        .o_seq         (n_seq),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    ttc_out_queue u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (advance && res_valid),
        .i_push_data (res),
        .o_full      (q_full),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_data      (out_data)
    );

    assign o_out_char      = out_data.out_char;
    assign o_char_position = out_data.char_position;
    assign o_line_done     = out_data.line_done;
    assign o_status        = out_data.status;

endmodule

/* rtl/core/ttc_checker.sv */
`include "text_line_charset_transcoder_unit_macros.svh"

module ttc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_char,
    input logic [5:0] o_char_position,
    input logic       o_line_done,
    input logic       o_status
);

    // A result held by the sink keeps its payload.
    `TTC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_char) && $stable(o_char_position) && $stable(o_line_done) && $stable(o_status))

    // The input side only stalls when results are backed up.
    `TTC_ASSERT_SAME(a_stall_full, i_clk, i_rst_n, o_in_stall, o_out_valid)

    // A read error is only reported on a terminator, which carries no character.
    `TTC_ASSERT_SAME(a_status_term, i_clk, i_rst_n, o_out_valid && o_status, o_line_done && o_out_char == 8'd0)

    // Reset empties the output stage.
    `TTC_ASSERT_NEXT_ALL(a_reset_empty, i_clk, !i_rst_n, !o_out_valid && !o_in_stall)

endmodule

bind text_line_charset_transcoder_unit ttc_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_out_char      (o_out_char),
    .o_char_position (o_char_position),
    .o_line_done     (o_line_done),
    .o_status        (o_status)
);
